// ----- hdl/ssq_pkg.sv -----
// ----------------------------------------------------------------------------
// ssq_pkg
// Shared types and constants of the step sequencer engine: operation codes,
// register indexes, configuration and result structures.
// ----------------------------------------------------------------------------
`default_nettype none

package ssq_pkg;

   // operation codes carried in the request tuser
   typedef enum logic [2:0] {
      OP_TICK   = 3'd0,
      OP_STEP   = 3'd1,
      OP_PAGE   = 3'd2,
      OP_NOTE   = 3'd3,
      OP_LENGTH = 3'd4,
      OP_GATE   = 3'd5,
      OP_TRACK  = 3'd6,
      OP_NONE   = 3'd7
   } op_type;

   // register indexes on the csr port (byte address is 4 * index)
   localparam logic [2:0] REG_RUNNING      = 3'd0;
   localparam logic [2:0] REG_QUARTER_MODE = 3'd1;
   localparam logic [2:0] REG_STEP_TICKS   = 3'd2;
   localparam logic [2:0] REG_DAC_PER_SEMI = 3'd3;
   localparam logic [2:0] REG_MIN_LENGTH   = 3'd4;

   // register reset values
   localparam logic [15:0] STEP_TICKS_RST = 16'd500;
   localparam logic [15:0] DAC_PER_SEMI_RST = 16'd8192;
   localparam logic [7:0]  MIN_LENGTH_RST = 8'd1;

   // bus widths
   localparam int CSR_AW      = 5;
   localparam int CSR_DW      = 32;
   localparam int REQ_TDATA_W = 8;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 104;

   // step entry layout: gate, note, length
   localparam int ENTRY_W  = 16;
   localparam int CHANNELS = 4;
   localparam int TICK_W   = 17;
   localparam int CMP_W    = 30;

   localparam logic [6:0] NOTE_MAX = 7'd127;
   localparam logic [7:0] LEN_MAX  = 8'd255;

   // gate drops once 19 * step_ticks * length < GATE_TICK_K * ticks
   localparam logic [12:0] GATE_TICK_K = 13'd5100;

   typedef struct packed {
      logic        running;
      logic        quarter_mode;
      logic [15:0] step_ticks;
      logic [15:0] dac_per_semitone;
      logic [7:0]  min_length;
   } cfg_type;

   typedef struct packed {
      logic [CHANNELS-1:0]       gates;
      logic [CHANNELS-1:0][15:0] dac;
      logic                      step_advanced;
      logic [5:0]                play_step;
      logic [5:0]                selected_step;
      logic [1:0]                selected_track;
      logic [6:0]                selected_note;
      logic [7:0]                selected_length;
   } rsp_type;

endpackage

`default_nettype wire

// ----- hdl/step_sequencer_engine_top.sv -----
// ----------------------------------------------------------------------------
// step_sequencer_engine_top
// Four-channel gate and cv step sequencer with a csr port for setup.
// ----------------------------------------------------------------------------
// flow: step moves up and page moves wrap by repeated subtraction; running ticks
//   scan each channel in turn, after the wrap subtractions on a step change; all
//   other items go straight to the result
// throughput: one item at a time, next accept in the cycle the result appears;
//   the per-channel scan through the shared multiplier and memory port sets tick time
// reset: state cleared, all 256 step memory entries swept to zero before req_tready
`default_nettype none

module step_sequencer_engine_top #(
   parameter int STEPS      = 64,
   parameter int TRACKS     = 4,
   parameter int PAGE_STEPS = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request: tdata = direction[0], track[2:1], zero fill
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [ssq_pkg::REQ_TDATA_W-1:0] req_tdata,
   // request: tuser = operation[2:0]
   input  wire logic [ssq_pkg::REQ_TUSER_W-1:0] req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // response: tdata = gates[3:0], dac_zero[19:4], dac_one[35:20],
   // dac_two[51:36], dac_three[67:52], step_advanced[68], play_step[74:69],
   // selected_step[80:75], selected_track[82:81], selected_note[89:83],
   // selected_length[97:90], zero fill
   output logic [ssq_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [ssq_pkg::CSR_AW-1:0]      csr_paddr,
   input  wire logic [ssq_pkg::CSR_DW-1:0]      csr_pwdata,
   output logic [ssq_pkg::CSR_DW-1:0]           csr_prdata,
   output logic                                 csr_pready
);

   localparam int SW = $clog2(STEPS);
   localparam int TW = (TRACKS > 1) ? $clog2(TRACKS) : 1;
   localparam int AW = SW + TW;

   logic                        running_ff;
   logic                        quarter_ff;
   logic [15:0]                 step_ticks_ff;
   logic [15:0]                 dac_semi_ff;
   logic [7:0]                  min_len_ff;
   logic [2:0]                  csr_index;
   logic                        csr_write;
   ssq_pkg::cfg_type            cfg;
   ssq_pkg::rsp_type            rsp;
   logic                        mem_busy;
   logic [AW-1:0]               mem_raddr;
   logic [ssq_pkg::ENTRY_W-1:0] mem_rdata;
   logic                        mem_we;
   logic [AW-1:0]               mem_waddr;
   logic [ssq_pkg::ENTRY_W-1:0] mem_wdata;
   logic [15:0]                 mul_a;
   logic [7:0]                  mul_b;
   logic [23:0]                 mul_prod;

   // csr decode
   assign csr_index  = csr_paddr[4:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff    <= 1'b0;
         quarter_ff    <= 1'b0;
         step_ticks_ff <= ssq_pkg::STEP_TICKS_RST;
         dac_semi_ff   <= ssq_pkg::DAC_PER_SEMI_RST;
         min_len_ff    <= ssq_pkg::MIN_LENGTH_RST;
      end else if (csr_write) begin
         case (csr_index)
            ssq_pkg::REG_RUNNING:      running_ff    <= csr_pwdata[0];
            ssq_pkg::REG_QUARTER_MODE: quarter_ff    <= csr_pwdata[0];
            ssq_pkg::REG_STEP_TICKS:   step_ticks_ff <= csr_pwdata[15:0];
            ssq_pkg::REG_DAC_PER_SEMI: dac_semi_ff   <= csr_pwdata[15:0];
            ssq_pkg::REG_MIN_LENGTH:   min_len_ff    <= csr_pwdata[7:0];
            default: begin
            end
         endcase
      end
   end

   // csr read back
   always_comb begin
      case (csr_index)
         ssq_pkg::REG_RUNNING:      csr_prdata = 32'(running_ff);
         ssq_pkg::REG_QUARTER_MODE: csr_prdata = 32'(quarter_ff);
         ssq_pkg::REG_STEP_TICKS:   csr_prdata = 32'(step_ticks_ff);
         ssq_pkg::REG_DAC_PER_SEMI: csr_prdata = 32'(dac_semi_ff);
         ssq_pkg::REG_MIN_LENGTH:   csr_prdata = 32'(min_len_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   assign cfg.running          = running_ff;
   assign cfg.quarter_mode     = quarter_ff;
   assign cfg.step_ticks       = step_ticks_ff;
   assign cfg.dac_per_semitone = dac_semi_ff;
   assign cfg.min_length       = min_len_ff;

   ssq_store #(
      .AW (AW)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .busy     (mem_busy),
      .raddr    (mem_raddr),
      .rdata_ff (mem_rdata),
      .we       (mem_we),
      .waddr    (mem_waddr),
      .wdata    (mem_wdata)
   );

   ssq_alu u_alu (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (mul_prod)
   );

   ssq_ctrl #(
      .STEPS      (STEPS),
      .TRACKS     (TRACKS),
      .PAGE_STEPS (PAGE_STEPS),
      .AW         (AW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_op     (ssq_pkg::op_type'(req_tuser[2:0])),
      .in_dir    (req_tdata[0]),
      .in_trk    (req_tdata[2:1]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rsp   (rsp),
      .mem_busy  (mem_busy),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mul_a     (mul_a),
      .mul_b     (mul_b),
      .mul_prod  (mul_prod)
   );

   // response packing, first field in the low bits
   assign rsp_tdata = {6'b0, rsp.selected_length, rsp.selected_note, rsp.selected_track,
                       rsp.selected_step, rsp.play_step, rsp.step_advanced,
                       rsp.dac[3], rsp.dac[2], rsp.dac[1], rsp.dac[0], rsp.gates};

endmodule

`default_nettype wire

// ----- hdl/ssq_store.sv -----
// ----------------------------------------------------------------------------
// ssq_store
// Step entry memory addressed by {step, track}: one write port, one read port
// with registered data, and a clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module ssq_store #(
   parameter int AW = 8
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   output logic                             busy,
   input  wire logic [AW-1:0]               raddr,
   output logic [ssq_pkg::ENTRY_W-1:0]      rdata_ff,
   input  wire logic                        we,
   input  wire logic [AW-1:0]               waddr,
   input  wire logic [ssq_pkg::ENTRY_W-1:0] wdata
);

   localparam int DEPTH = 2 ** AW;

   logic [ssq_pkg::ENTRY_W-1:0] store_ff [0:DEPTH-1];
   logic                        clr_busy_ff;
   logic [AW-1:0]               clr_addr_ff;

   // clearing sweep, one entry a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == '1) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // write port, shared with the sweep
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         store_ff[clr_addr_ff] <= '0;
      end else if (we) begin
         store_ff[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rdata_ff <= store_ff[raddr];
   end

   assign busy = clr_busy_ff;

endmodule

`default_nettype wire

// ----- hdl/ssq_alu.sv -----
// ----------------------------------------------------------------------------
// ssq_alu
// Shared 16 x 8 multiplier with a registered product, used for both the
// note to dac scaling and the gate length product.
// ----------------------------------------------------------------------------
`default_nettype none

module ssq_alu (
   input  wire logic        clock,
   input  wire logic [15:0] mul_a,
   input  wire logic [7:0]  mul_b,
   output logic [23:0]      prod_ff
);

   // one multiply per cycle
   always_ff @(posedge clock) begin
      prod_ff <= 24'(mul_a) * 24'(mul_b);
   end

endmodule

`default_nettype wire

// ----- hdl/ssq_ctrl.sv -----
// ----------------------------------------------------------------------------
// ssq_ctrl
// Sequencer for the step sequencer engine: edit operations, tick timing,
// per-channel scan over the shared multiplier and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ssq_ctrl #(
   parameter int STEPS      = 64,
   parameter int TRACKS     = 4,
   parameter int PAGE_STEPS = 16,
   parameter int AW         = 8
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire ssq_pkg::cfg_type            cfg,
   input  wire logic                        in_valid,
   output logic                             in_ready,
   input  wire ssq_pkg::op_type             in_op,
   input  wire logic                        in_dir,
   input  wire logic [1:0]                  in_trk,
   output logic                             out_valid,
   input  wire logic                        out_ready,
   output ssq_pkg::rsp_type                 out_rsp,
   input  wire logic                        mem_busy,
   output logic [AW-1:0]                    mem_raddr,
   input  wire logic [ssq_pkg::ENTRY_W-1:0] mem_rdata,
   output logic                             mem_we,
   output logic [AW-1:0]                    mem_waddr,
   output logic [ssq_pkg::ENTRY_W-1:0]      mem_wdata,
   output logic [15:0]                      mul_a,
   output logic [7:0]                       mul_b,
   input  wire logic [23:0]                 mul_prod
);

   localparam int SW        = $clog2(STEPS);
   localparam int TW        = AW - SW;
   localparam int LW        = $clog2(STEPS + 1);
   localparam int RW        = $clog2(2 * STEPS + PAGE_STEPS);
   localparam int NCH       = (TRACKS < ssq_pkg::CHANNELS) ? TRACKS : ssq_pkg::CHANNELS;
   localparam int QLIM      = (PAGE_STEPS < STEPS) ? PAGE_STEPS : STEPS;
   localparam int PAGE_DOWN = STEPS - (PAGE_STEPS % STEPS);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_REDUCE,
      ST_RHS,
      ST_RD,
      ST_MUL,
      ST_ACC,
      ST_FINAL,
      ST_OUT
   } state_type;

   state_type                      state_ff;
   ssq_pkg::op_type                op_ff;
   logic                           dir_ff;
   logic [1:0]                     trk_ff;
   logic [SW-1:0]                  pos_ff;
   logic [ssq_pkg::TICK_W-1:0]     tick_ff;
   logic [SW-1:0]                  edit_step_ff;
   logic [TW-1:0]                  edit_trk_ff;
   logic [ssq_pkg::CHANNELS-1:0]   gates_ff;
   logic [ssq_pkg::CHANNELS-1:0][15:0] dac_ff;
   logic                           adv_ff;
   logic [1:0]                     ch_ff;
   logic                           gate_ff;
   logic [ssq_pkg::CMP_W-1:0]      rhs_ff;
   logic [RW-1:0]                  red_val_ff;
   logic [RW-1:0]                  red_mod_ff;
   logic                           red_pos_ff;
   logic                           out_valid_ff;
   ssq_pkg::rsp_type               out_ff;

   logic [AW-1:0]                  sel_addr;
   logic [LW-1:0]                  lim;
   logic [ssq_pkg::TICK_W-1:0]     tick_in;
   logic                           cur_gate;
   logic [6:0]                     cur_note;
   logic [7:0]                     cur_len;
   logic [6:0]                     note_in;
   logic [7:0]                     len_in;
   logic [ssq_pkg::ENTRY_W-1:0]    entry_in;
   logic [ssq_pkg::CMP_W-1:0]      lhs;
   logic                           out_free;

   // decoded entry and common values
   assign sel_addr = {edit_step_ff, edit_trk_ff};
   assign lim      = cfg.quarter_mode ? LW'(QLIM) : LW'(STEPS);
   assign tick_in  = tick_ff + 1'b1;
   assign cur_gate = mem_rdata[15];
   assign cur_note = mem_rdata[14:8];
   assign cur_len  = mem_rdata[7:0];
   assign out_free = !out_valid_ff || out_ready;

   // gate length product times nineteen by shift and add
   assign lhs = (ssq_pkg::CMP_W'(mul_prod) << 4) + (ssq_pkg::CMP_W'(mul_prod) << 1)
              + ssq_pkg::CMP_W'(mul_prod);

   // saturating note and length nudges
   always_comb begin
      if (dir_ff) begin
         note_in = (cur_note < ssq_pkg::NOTE_MAX) ? cur_note + 1'b1 : ssq_pkg::NOTE_MAX;
         len_in  = (cur_len < ssq_pkg::LEN_MAX) ? cur_len + 1'b1 : ssq_pkg::LEN_MAX;
      end else begin
         note_in = (cur_note == '0) ? '0 : cur_note - 1'b1;
         len_in  = (cur_len > cfg.min_length) ? cur_len - 1'b1 : cfg.min_length;
      end
   end

   // edited entry
   always_comb begin
      case (op_ff)
         ssq_pkg::OP_NOTE:   entry_in = {cur_gate, note_in, cur_len};
         ssq_pkg::OP_LENGTH: entry_in = {cur_gate, cur_note, len_in};
         ssq_pkg::OP_GATE:   entry_in = {!cur_gate, cur_note, cur_len};
         default:            entry_in = mem_rdata;
      endcase
   end

   // memory port and shared multiplier operands
   always_comb begin
      mem_raddr = (state_ff == ST_RD) ? {pos_ff, TW'(ch_ff)} : sel_addr;
      mem_we    = (state_ff == ST_DISPATCH) &&
                  (op_ff inside {ssq_pkg::OP_NOTE, ssq_pkg::OP_LENGTH, ssq_pkg::OP_GATE});
      mem_waddr = sel_addr;
      mem_wdata = entry_in;
      mul_a     = adv_ff ? cfg.dac_per_semitone : cfg.step_ticks;
      mul_b     = adv_ff ? {1'b0, cur_note} : cur_len;
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         tick_ff      <= '0;
         edit_step_ff <= '0;
         edit_trk_ff  <= '0;
         gates_ff     <= '0;
         dac_ff       <= '0;
         adv_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         // result slot: filled when leaving the output state, emptied on accept
         if (state_ff == ST_OUT && out_free) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (in_valid && !mem_busy) begin
                  op_ff    <= in_op;
                  dir_ff   <= in_dir;
                  trk_ff   <= in_trk;
                  adv_ff   <= 1'b0;
                  state_ff <= ST_DISPATCH;
               end
            end
            ST_DISPATCH: begin
               state_ff <= ST_FINAL;
               case (op_ff)
                  ssq_pkg::OP_TICK: begin
                     if (!cfg.running) begin
                        gates_ff <= '0;
                        dac_ff   <= '0;
                     end else if (tick_in > {1'b0, cfg.step_ticks}) begin
                        tick_ff    <= tick_in - ssq_pkg::TICK_W'(cfg.step_ticks);
                        adv_ff     <= 1'b1;
                        gates_ff   <= '0;
                        red_val_ff <= RW'(pos_ff) + 1'b1;
                        red_mod_ff <= RW'(lim);
                        red_pos_ff <= 1'b1;
                        state_ff   <= ST_REDUCE;
                     end else begin
                        tick_ff  <= tick_in;
                        state_ff <= ST_RHS;
                     end
                  end
                  ssq_pkg::OP_STEP: begin
                     if (dir_ff) begin
                        red_val_ff <= RW'(edit_step_ff) + 1'b1;
                        red_mod_ff <= RW'(lim);
                        red_pos_ff <= 1'b0;
                        state_ff   <= ST_REDUCE;
                     end else if (edit_step_ff == '0) begin
                        edit_step_ff <= SW'(lim - 1'b1);
                     end else begin
                        edit_step_ff <= edit_step_ff - 1'b1;
                     end
                  end
                  ssq_pkg::OP_PAGE: begin
                     if (!cfg.running && !cfg.quarter_mode) begin
                        red_val_ff <= dir_ff ? RW'(edit_step_ff) + RW'(PAGE_STEPS)
                                             : RW'(edit_step_ff) + RW'(PAGE_DOWN);
                        red_mod_ff <= RW'(STEPS);
                        red_pos_ff <= 1'b0;
                        state_ff   <= ST_REDUCE;
                     end
                  end
                  ssq_pkg::OP_TRACK: begin
                     if (32'(trk_ff) < TRACKS) begin
                        edit_trk_ff <= TW'(trk_ff);
                     end
                  end
                  default: begin
                  end
               endcase
            end
            // modulo by repeated subtraction
            ST_REDUCE: begin
               if (red_val_ff >= red_mod_ff) begin
                  red_val_ff <= red_val_ff - red_mod_ff;
               end else if (red_pos_ff) begin
                  pos_ff   <= SW'(red_val_ff);
                  ch_ff    <= '0;
                  state_ff <= ST_RD;
               end else begin
                  edit_step_ff <= SW'(red_val_ff);
                  state_ff     <= ST_FINAL;
               end
            end
            ST_RHS: begin
               rhs_ff   <= ssq_pkg::CMP_W'(tick_ff) * ssq_pkg::CMP_W'(ssq_pkg::GATE_TICK_K);
               ch_ff    <= '0;
               state_ff <= ST_RD;
            end
            // per-channel scan: read, multiply, use
            ST_RD: begin
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               gate_ff  <= cur_gate;
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               if (adv_ff) begin
                  gates_ff[ch_ff] <= gate_ff;
                  dac_ff[ch_ff]   <= mul_prod[23:8];
               end else if (gate_ff && (lhs < rhs_ff)) begin
                  gates_ff[ch_ff] <= 1'b0;
               end
               if (ch_ff == 2'(NCH - 1)) begin
                  state_ff <= ST_FINAL;
               end else begin
                  ch_ff    <= ch_ff + 1'b1;
                  state_ff <= ST_RD;
               end
            end
            ST_FINAL: begin
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (state_ff == ST_OUT && out_free) begin
         out_ff.gates           <= cfg.running ? gates_ff : '0;
         out_ff.dac             <= cfg.running ? dac_ff : '0;
         out_ff.step_advanced   <= adv_ff;
         out_ff.play_step       <= 6'(pos_ff);
         out_ff.selected_step   <= 6'(edit_step_ff);
         out_ff.selected_track  <= 2'(edit_trk_ff);
         out_ff.selected_note   <= cur_note;
         out_ff.selected_length <= cur_len;
      end
   end

   assign in_ready  = (state_ff == ST_IDLE) && !mem_busy;
   assign out_valid = out_valid_ff;
   assign out_rsp   = out_ff;

endmodule

`default_nettype wire

// ----- hdl/ssq_checker.sv -----
// ----------------------------------------------------------------------------
// ssq_checker
// Port-level checks of the step sequencer engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ssq_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [ssq_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // one item at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

   // reset empties the result slot and starts the memory sweep
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("not quiet after reset");

   // padding bits of the result stay zero
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[103:98] == 6'b0)
      else $error("response padding not zero");

endmodule

bind step_sequencer_engine_top ssq_checker u_ssq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
